// ===== design/bres_pkg.sv =====
// Shared types and constants of the Bresenham line rasterizer.
package bres_pkg;

	localparam int COORD_BITS = 12;
	localparam int ERR_BITS   = COORD_BITS + 2;
	localparam int VIEW_BITS  = 11;
	localparam int RGB_BITS   = 24;
	localparam int CMP_BITS   = (COORD_BITS > VIEW_BITS) ? COORD_BITS : VIEW_BITS;
	localparam int CFG_IDX_BITS = 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [ERR_BITS-1:0]   err_t;
	typedef logic [VIEW_BITS-1:0]         view_t;
	typedef logic [RGB_BITS-1:0]          rgb_t;
	typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	localparam cfg_idx_t REG_VIEW_WIDTH  = 1'b0;
	localparam cfg_idx_t REG_VIEW_HEIGHT = 1'b1;

	localparam view_t VIEW_RESET = view_t'(1024);

endpackage

// ===== design/bres_cmd_if.sv =====
// Command channel of the rasterizer: line start and step transactions.
interface bres_cmd_if;
	logic               valid;
	logic               ready;
	logic               kind;
	bres_pkg::coord_t   x_start;
	bres_pkg::coord_t   y_start;
	bres_pkg::coord_t   x_end;
	bres_pkg::coord_t   y_end;
	bres_pkg::rgb_t     rgb;

	modport source (output valid, kind, x_start, y_start, x_end, y_end, rgb, input ready);
	modport sink (input valid, kind, x_start, y_start, x_end, y_end, rgb, output ready);
endinterface

// ===== design/bres_pix_if.sv =====
// Pixel channel of the rasterizer: one transaction per produced result.
interface bres_pix_if;
	logic               valid;
	logic               ready;
	bres_pkg::coord_t   pixel_x;
	bres_pkg::coord_t   pixel_y;
	bres_pkg::rgb_t     pixel_rgb;
	logic               has_pixel;
	logic               inside_view;
	logic               last;

	modport source (output valid, pixel_x, pixel_y, pixel_rgb, has_pixel, inside_view, last,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_rgb, has_pixel, inside_view, last,
		output ready);
endinterface

// ===== design/bresenham_line_rasterizer.sv =====
// Bresenham line rasterizer, all octants. Every command transaction yields exactly one pixel
// transaction. A command is captured in an input register and its pixel is computed from it
// into an output register, which offers it; the block sustains one command per clock as long
// as the pixel side keeps ready high. The rate is set by the line state loop: error add,
// coordinate step and end compare run combinationally from the line state registers back in.
// A start command (kind 0) emits the first pixel, each step command (kind 1) the next one; a
// step with no line in progress returns an all-zero result with has_pixel low. view_width and
// view_height are written through the cfg port; the user must write them only while the block
// is idle, which the block itself does not enforce.
module bresenham_line_rasterizer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  bres_pkg::cfg_idx_t  cfg_index,
	input  bres_pkg::view_t     cfg_data,
	bres_cmd_if.sink            cmd,
	bres_pix_if.source          pix
);

	localparam int C = bres_pkg::COORD_BITS;
	localparam int E = bres_pkg::ERR_BITS;

	// Configuration registers.
	bres_pkg::view_t view_width_q;
	bres_pkg::view_t view_height_q;

	// Input stage.
	logic               valid_s1;
	logic               kind_s1;
	bres_pkg::coord_t   x_start_s1;
	bres_pkg::coord_t   y_start_s1;
	bres_pkg::coord_t   x_end_s1;
	bres_pkg::coord_t   y_end_s1;
	bres_pkg::rgb_t     rgb_s1;

	// Line state.
	bres_pkg::coord_t   cur_x_q;
	bres_pkg::coord_t   cur_y_q;
	bres_pkg::coord_t   major_stop_q;
	bres_pkg::err_t     error_term_q;
	bres_pkg::err_t     inc_straight_q;
	bres_pkg::err_t     inc_diagonal_q;
	logic               x_is_major_q;
	logic               minor_down_q;
	logic               line_active_q;
	bres_pkg::rgb_t     line_rgb_q;

	// Output stage.
	logic               valid_s2;
	bres_pkg::coord_t   pixel_x_s2;
	bres_pkg::coord_t   pixel_y_s2;
	bres_pkg::rgb_t     pixel_rgb_s2;
	logic               has_pixel_s2;
	logic               inside_view_s2;
	logic               last_s2;

	logic advance;
	logic is_start;

	// Start decode.
	logic signed [C:0]  dx;
	logic signed [C:0]  dy;
	logic [C-1:0]       adx;
	logic [C-1:0]       ady;
	logic               st_x_major;
	logic [C-1:0]       st_maj;
	logic [C-1:0]       st_mnr;
	bres_pkg::err_t     two_mnr;
	bres_pkg::err_t     st_err;
	bres_pkg::err_t     st_inc_s;
	bres_pkg::err_t     st_inc_d;
	logic               st_minor_down;
	logic               st_fwd;
	bres_pkg::coord_t   st_x;
	bres_pkg::coord_t   st_y;
	bres_pkg::coord_t   st_stop;
	logic               st_last;

	// Step decode.
	logic               go_straight;
	bres_pkg::coord_t   minor_delta;
	bres_pkg::coord_t   sp_x;
	bres_pkg::coord_t   sp_y;
	bres_pkg::err_t     sp_err;
	logic               sp_last;

	// Next values.
	bres_pkg::coord_t   nxt_x;
	bres_pkg::coord_t   nxt_y;
	logic               nxt_has;
	logic               nxt_last;
	logic               nxt_inside;
	logic [bres_pkg::CMP_BITS-1:0] nx_u;
	logic [bres_pkg::CMP_BITS-1:0] ny_u;

	assign advance   = valid_s1 && (!valid_s2 || pix.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign is_start  = (kind_s1 == bres_pkg::KIND_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_width_q  <= bres_pkg::VIEW_RESET;
			view_height_q <= bres_pkg::VIEW_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bres_pkg::REG_VIEW_WIDTH:  view_width_q  <= cfg_data;
				bres_pkg::REG_VIEW_HEIGHT: view_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		dx = $signed({x_end_s1[C-1], x_end_s1}) - $signed({x_start_s1[C-1], x_start_s1});
		dy = $signed({y_end_s1[C-1], y_end_s1}) - $signed({y_start_s1[C-1], y_start_s1});
		adx = dx[C] ? C'(-dx) : C'(dx);
		ady = dy[C] ? C'(-dy) : C'(dy);
		st_x_major = (ady <= adx);
		st_maj = st_x_major ? adx : ady;
		st_mnr = st_x_major ? ady : adx;
		two_mnr  = $signed({1'b0, st_mnr, 1'b0});
		st_err   = two_mnr - $signed({2'b00, st_maj});
		st_inc_s = two_mnr;
		st_inc_d = two_mnr - $signed({1'b0, st_maj, 1'b0});
		// Minor axis goes down unless both deltas are strictly the same sign.
		st_minor_down = !((dx[C] && dy[C]) ||
			(!dx[C] && (dx != '0) && !dy[C] && (dy != '0)));
		st_fwd = st_x_major ? !dx[C] : !dy[C];
		st_x = st_fwd ? x_start_s1 : x_end_s1;
		st_y = st_fwd ? y_start_s1 : y_end_s1;
		if (st_x_major) begin
			st_stop = st_fwd ? x_end_s1 : x_start_s1;
			st_last = (st_x >= st_stop);
		end else begin
			st_stop = st_fwd ? y_end_s1 : y_start_s1;
			st_last = (st_y >= st_stop);
		end
	end

	always_comb begin
		// The x-major case keeps the minor coordinate while the error is negative,
		// the y-major case also while it is zero.
		go_straight = x_is_major_q ? error_term_q[E-1] :
			(error_term_q[E-1] || (error_term_q == '0));
		minor_delta = minor_down_q ? '1 : C'(1);
		sp_err = go_straight ? (error_term_q + inc_straight_q) :
			(error_term_q + inc_diagonal_q);
		if (x_is_major_q) begin
			sp_x = cur_x_q + C'(1);
			sp_y = go_straight ? cur_y_q : (cur_y_q + minor_delta);
			sp_last = (sp_x >= major_stop_q);
		end else begin
			sp_y = cur_y_q + C'(1);
			sp_x = go_straight ? cur_x_q : (cur_x_q + minor_delta);
			sp_last = (sp_y >= major_stop_q);
		end
	end

	always_comb begin
		if (is_start) begin
			nxt_x = st_x;
			nxt_y = st_y;
			nxt_has = 1'b1;
			nxt_last = st_last;
		end else if (line_active_q) begin
			nxt_x = sp_x;
			nxt_y = sp_y;
			nxt_has = 1'b1;
			nxt_last = sp_last;
		end else begin
			nxt_x = '0;
			nxt_y = '0;
			nxt_has = 1'b0;
			nxt_last = 1'b0;
		end
		nx_u = bres_pkg::CMP_BITS'($unsigned(nxt_x));
		ny_u = bres_pkg::CMP_BITS'($unsigned(nxt_y));
		nxt_inside = nxt_has && !nxt_x[C-1] && !nxt_y[C-1] &&
			(nx_u < bres_pkg::CMP_BITS'(view_width_q)) &&
			(ny_u < bres_pkg::CMP_BITS'(view_height_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			kind_s1    <= cmd.kind;
			x_start_s1 <= cmd.x_start;
			y_start_s1 <= cmd.y_start;
			x_end_s1   <= cmd.x_end;
			y_end_s1   <= cmd.y_end;
			rgb_s1     <= cmd.rgb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q        <= '0;
			cur_y_q        <= '0;
			major_stop_q   <= '0;
			error_term_q   <= '0;
			inc_straight_q <= '0;
			inc_diagonal_q <= '0;
			x_is_major_q   <= 1'b0;
			minor_down_q   <= 1'b0;
			line_active_q  <= 1'b0;
			line_rgb_q     <= '0;
		end else if (advance) begin
			if (is_start) begin
				cur_x_q        <= st_x;
				cur_y_q        <= st_y;
				major_stop_q   <= st_stop;
				error_term_q   <= st_err;
				inc_straight_q <= st_inc_s;
				inc_diagonal_q <= st_inc_d;
				x_is_major_q   <= st_x_major;
				minor_down_q   <= st_minor_down;
				line_active_q  <= !st_last;
				line_rgb_q     <= rgb_s1;
			end else if (line_active_q) begin
				cur_x_q       <= sp_x;
				cur_y_q       <= sp_y;
				error_term_q  <= sp_err;
				line_active_q <= !sp_last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || pix.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pixel_x_s2     <= nxt_x;
			pixel_y_s2     <= nxt_y;
			pixel_rgb_s2   <= is_start ? rgb_s1 : (line_active_q ? line_rgb_q : '0);
			has_pixel_s2   <= nxt_has;
			inside_view_s2 <= nxt_inside;
			last_s2        <= nxt_last;
		end
	end

	assign pix.valid       = valid_s2;
	assign pix.pixel_x     = pixel_x_s2;
	assign pix.pixel_y     = pixel_y_s2;
	assign pix.pixel_rgb   = pixel_rgb_s2;
	assign pix.has_pixel   = has_pixel_s2;
	assign pix.inside_view = inside_view_s2;
	assign pix.last        = last_s2;

`ifndef SYNTH
	// A start transaction always produces a pixel in the next cycle.
	a_start_has_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_start |=> valid_s2 && has_pixel_s2)
		else $error("start transaction produced no pixel");

	// An empty result carries no other information.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !has_pixel_s2 |-> !inside_view_s2 && !last_s2 &&
			(pixel_x_s2 == '0) && (pixel_y_s2 == '0) && (pixel_rgb_s2 == '0))
		else $error("empty result has nonzero fields");

	// The final pixel of a line ends the line.
	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		advance && nxt_last |=> !line_active_q)
		else $error("line still active after its last pixel");

	// A step with no line in progress leaves the line state alone.
	a_idle_step_stable: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !is_start && !line_active_q |=>
			$stable(cur_x_q) && $stable(cur_y_q) && $stable(error_term_q) && !line_active_q)
		else $error("idle step changed the line state");
`endif

endmodule

// ===== bench/bresenham_line_rasterizer_tb.sv =====
// Testbench for the Bresenham line rasterizer: stimulus, line predictor and pixel checker.
`timescale 1ns / 1ps

module bresenham_line_rasterizer_tb;

	localparam int COORD_MAX    = 2 ** (bres_pkg::COORD_BITS - 1) - 1;
	localparam int COORD_MIN    = -(2 ** (bres_pkg::COORD_BITS - 1));
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_SETTLE = 8;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int PRINT_LIMIT  = 40;

	typedef struct packed {
		logic             kind;
		bres_pkg::coord_t x_start;
		bres_pkg::coord_t y_start;
		bres_pkg::coord_t x_end;
		bres_pkg::coord_t y_end;
		bres_pkg::rgb_t   rgb;
	} line_cmd_t;

	typedef struct packed {
		bres_pkg::coord_t pixel_x;
		bres_pkg::coord_t pixel_y;
		bres_pkg::rgb_t   pixel_rgb;
		logic             has_pixel;
		logic             inside_view;
		logic             last;
	} pixel_t;

	typedef enum int {ACCEPT_ALWAYS, ACCEPT_RANDOM, ACCEPT_SPARSE, ACCEPT_PERIODIC} accept_mode_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	bres_pkg::cfg_idx_t cfg_index;
	bres_pkg::view_t    cfg_data;

	bres_cmd_if cmd_ch();
	bres_pix_if pix_ch();

	bresenham_line_rasterizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.pix       (pix_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the line state and of the viewport registers.
	int             view_w = int'(bres_pkg::VIEW_RESET);
	int             view_h = int'(bres_pkg::VIEW_RESET);
	int             ln_x = 0;
	int             ln_y = 0;
	int             ln_stop = 0;
	int             ln_err = 0;
	int             ln_inc_str = 0;
	int             ln_inc_diag = 0;
	logic           ln_xmajor = 1'b0;
	logic           ln_down = 1'b0;
	logic           ln_active = 1'b0;
	bres_pkg::rgb_t ln_rgb = '0;

	pixel_t      pending_pixels[$];
	pixel_t      seen_pixel;
	pixel_t      due_pixel;
	int          mismatch_count = 0;
	int          results_seen = 0;
	int          items_sent = 0;
	int          burst_left = 0;
	logic        hold_pixels = 1'b0;
	int unsigned cycle_count = 0;

	function automatic pixel_t next_pixel(line_cmd_t c);
		pixel_t p;
		int     x1, y1, x2, y2, dx, dy, adx, ady;
		logic   at_end;
		p = '0;
		if (c.kind == bres_pkg::KIND_START) begin
			x1 = int'(c.x_start);
			y1 = int'(c.y_start);
			x2 = int'(c.x_end);
			y2 = int'(c.y_end);
			dx = x2 - x1;
			dy = y2 - y1;
			adx = (dx < 0) ? -dx : dx;
			ady = (dy < 0) ? -dy : dy;
			ln_rgb = c.rgb;
			ln_down = !((dx < 0 && dy < 0) || (dx > 0 && dy > 0));
			ln_xmajor = (ady <= adx);
			if (ln_xmajor) begin
				ln_err = 2 * ady - adx;
				ln_inc_str = 2 * ady;
				ln_inc_diag = 2 * (ady - adx);
				if (dx >= 0) begin
					ln_x = x1; ln_y = y1; ln_stop = x2;
				end else begin
					ln_x = x2; ln_y = y2; ln_stop = x1;
				end
				at_end = (ln_x >= ln_stop);
			end else begin
				ln_err = 2 * adx - ady;
				ln_inc_str = 2 * adx;
				ln_inc_diag = 2 * (adx - ady);
				if (dy >= 0) begin
					ln_x = x1; ln_y = y1; ln_stop = y2;
				end else begin
					ln_x = x2; ln_y = y2; ln_stop = y1;
				end
				at_end = (ln_y >= ln_stop);
			end
			ln_active = !at_end;
		end else if (!ln_active) begin
			return p;
		end else begin
			// The x-major walk steps the minor axis on a non-negative error, the y-major
			// walk only on a positive one.
			if (ln_xmajor) begin
				ln_x++;
				if (ln_err < 0) begin
					ln_err += ln_inc_str;
				end else begin
					ln_y += ln_down ? -1 : 1;
					ln_err += ln_inc_diag;
				end
				at_end = (ln_x >= ln_stop);
			end else begin
				ln_y++;
				if (ln_err <= 0) begin
					ln_err += ln_inc_str;
				end else begin
					ln_x += ln_down ? -1 : 1;
					ln_err += ln_inc_diag;
				end
				at_end = (ln_y >= ln_stop);
			end
			if (at_end) begin
				ln_active = 1'b0;
			end
		end
		p.pixel_x = bres_pkg::coord_t'(ln_x);
		p.pixel_y = bres_pkg::coord_t'(ln_y);
		p.pixel_rgb = ln_rgb;
		p.has_pixel = 1'b1;
		p.inside_view = (ln_x >= 0 && ln_y >= 0 && ln_x < view_w && ln_y < view_h);
		p.last = at_end;
		return p;
	endfunction

	function automatic bres_pkg::coord_t near(int centre, int spread);
		int v;
		v = centre + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > COORD_MAX) begin
			v = COORD_MAX;
		end
		if (v < COORD_MIN) begin
			v = COORD_MIN;
		end
		return bres_pkg::coord_t'(v);
	endfunction

	// Origins cluster around the viewport edges so that inside_view toggles often.
	function automatic bres_pkg::coord_t pick_origin(int limit);
		case ($urandom_range(0, 3))
			0: return near(0, 6);
			1: return near(limit, 6);
			default: return bres_pkg::coord_t'($urandom);
		endcase
	endfunction

	function automatic int line_span(bres_pkg::coord_t x0, bres_pkg::coord_t y0,
		bres_pkg::coord_t x1, bres_pkg::coord_t y1);
		int adx, ady;
		adx = int'(x1) - int'(x0);
		ady = int'(y1) - int'(y0);
		adx = (adx < 0) ? -adx : adx;
		ady = (ady < 0) ? -ady : ady;
		return (adx > ady) ? adx : ady;
	endfunction

	function automatic line_cmd_t random_cmd();
		line_cmd_t c;
		c.kind = 1'($urandom);
		c.x_start = bres_pkg::coord_t'($urandom);
		c.y_start = bres_pkg::coord_t'($urandom);
		c.x_end = bres_pkg::coord_t'($urandom);
		c.y_end = bres_pkg::coord_t'($urandom);
		c.rgb = bres_pkg::rgb_t'($urandom);
		return c;
	endfunction

	function automatic line_cmd_t random_step();
		line_cmd_t c;
		c = random_cmd();
		c.kind = bres_pkg::KIND_STEP;
		return c;
	endfunction

	task automatic report_mismatch(string what, logic signed [31:0] got_v,
		logic signed [31:0] want_v);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT) begin
			$display("%0t: pixel %0d %s: got %0d, expected %0d", $time, results_seen, what,
				got_v, want_v);
		end
	endtask

	// Every input changes only at a rising edge, so the handshake is sampled at the falling edge
	// and the transaction is taken at the rising edge that follows.
	task automatic send_cmd(line_cmd_t c);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.kind <= c.kind;
		cmd_ch.x_start <= c.x_start;
		cmd_ch.y_start <= c.y_start;
		cmd_ch.x_end <= c.x_end;
		cmd_ch.y_end <= c.y_end;
		cmd_ch.rgb <= c.rgb;
		do @(negedge clk); while (!cmd_ch.ready);
		@(posedge clk);
		pending_pixels = {pending_pixels, next_pixel(c)};
		items_sent++;
		burst_left--;
	endtask

	task automatic draw_line(bres_pkg::coord_t x0, bres_pkg::coord_t y0, bres_pkg::coord_t x1,
		bres_pkg::coord_t y1, bres_pkg::rgb_t colour, int steps);
		line_cmd_t c;
		c.kind = bres_pkg::KIND_START;
		c.x_start = x0;
		c.y_start = y0;
		c.x_end = x1;
		c.y_end = y1;
		c.rgb = colour;
		send_cmd(c);
		repeat (steps) send_cmd(random_step());
	endtask

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_SETTLE) @(posedge clk);
	endtask

	task automatic write_view_reg(bres_pkg::cfg_idx_t idx, bres_pkg::view_t value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == bres_pkg::REG_VIEW_WIDTH) begin
			view_w = int'(value);
		end else begin
			view_h = int'(value);
		end
	endtask

	task automatic test_directed();
		send_cmd(random_step());
		draw_line(bres_pkg::coord_t'(5), bres_pkg::coord_t'(5), bres_pkg::coord_t'(5),
			bres_pkg::coord_t'(5), 24'hFFFFFF, 1);
		draw_line(bres_pkg::coord_t'(0), bres_pkg::coord_t'(0), bres_pkg::coord_t'(3),
			bres_pkg::coord_t'(1), 24'h000000, 3);
		draw_line(bres_pkg::coord_t'(1), bres_pkg::coord_t'(3), bres_pkg::coord_t'(0),
			bres_pkg::coord_t'(0), 24'hA5A5A5, 3);
		draw_line(bres_pkg::coord_t'(0), bres_pkg::coord_t'(2), bres_pkg::coord_t'(2),
			bres_pkg::coord_t'(0), 24'h5A5A5A, 2);
		// The extreme lines are cut short, so each start lands in the middle of a line.
		draw_line(bres_pkg::coord_t'(COORD_MIN), bres_pkg::coord_t'(COORD_MIN),
			bres_pkg::coord_t'(COORD_MAX), bres_pkg::coord_t'(COORD_MAX), 24'h123456, 2);
		draw_line(bres_pkg::coord_t'(COORD_MAX), bres_pkg::coord_t'(COORD_MIN),
			bres_pkg::coord_t'(COORD_MIN), bres_pkg::coord_t'(COORD_MAX), 24'hFEDCBA, 2);
		draw_line(bres_pkg::coord_t'(1022), bres_pkg::coord_t'(1021), bres_pkg::coord_t'(1025),
			bres_pkg::coord_t'(1024), 24'h0F0F0F, 3);
	endtask

	task automatic test_random_lines(int item_goal);
		int               first_item, span, steps;
		bres_pkg::coord_t x0, y0, x1, y1;
		first_item = items_sent;
		while (items_sent - first_item < item_goal) begin
			if ($urandom_range(0, 9) == 0) begin
				send_cmd(random_cmd());
			end else begin
				x0 = pick_origin(view_w);
				y0 = pick_origin(view_h);
				if ($urandom_range(0, 9) == 0) begin
					x1 = bres_pkg::coord_t'($urandom);
					y1 = bres_pkg::coord_t'($urandom);
				end else begin
					x1 = near(int'(x0), 12);
					y1 = near(int'(y0), 12);
				end
				span = line_span(x0, y0, x1, y1);
				case ($urandom_range(0, 6))
					0: steps = span + $urandom_range(1, 2);
					1: steps = $urandom_range(0, span);
					default: steps = span;
				endcase
				if (steps > 24) begin
					steps = $urandom_range(0, 24);
				end
				draw_line(x0, y0, x1, y1, bres_pkg::rgb_t'($urandom), steps);
			end
		end
	endtask

	task automatic test_output_backpressure();
		hold_pixels = 1'b1;
		draw_line(bres_pkg::coord_t'(-20), bres_pkg::coord_t'(5), bres_pkg::coord_t'(40),
			bres_pkg::coord_t'(-10), 24'h3C7E11, 39);
		wait_drained();
		test_random_lines(20);
		wait_drained();
	endtask

	task automatic test_view_settings();
		for (int k = 0; k < 5; k++) begin
			wait_drained();
			case (k)
				0: begin
					write_view_reg(bres_pkg::REG_VIEW_WIDTH, '0);
					write_view_reg(bres_pkg::REG_VIEW_HEIGHT, '1);
				end
				1: begin
					write_view_reg(bres_pkg::REG_VIEW_WIDTH, '1);
					write_view_reg(bres_pkg::REG_VIEW_HEIGHT, '0);
				end
				2: begin
					write_view_reg(bres_pkg::REG_VIEW_WIDTH, '1);
					write_view_reg(bres_pkg::REG_VIEW_HEIGHT, '1);
				end
				3: begin
					write_view_reg(bres_pkg::REG_VIEW_WIDTH, bres_pkg::view_t'(1));
					write_view_reg(bres_pkg::REG_VIEW_HEIGHT, bres_pkg::view_t'(1));
				end
				default: begin
					write_view_reg(bres_pkg::REG_VIEW_WIDTH, bres_pkg::view_t'($urandom));
					write_view_reg(bres_pkg::REG_VIEW_HEIGHT, bres_pkg::view_t'($urandom));
				end
			endcase
			test_random_lines(60);
		end
		wait_drained();
	endtask

	// Pixel side: switches among acceptance patterns and honors a requested long hold.
	initial begin
		accept_mode_t accept_mode;
		int           mode_left;
		int           phase;
		accept_mode = ACCEPT_ALWAYS;
		mode_left = 0;
		phase = 0;
		pix_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pixels) begin
				pix_ch.ready <= 1'b0;
				for (int n = 1; n < HOLD_CYCLES; n++) @(posedge clk);
				hold_pixels = 1'b0;
			end else begin
				if (mode_left == 0) begin
					accept_mode = accept_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				phase++;
				case (accept_mode)
					ACCEPT_ALWAYS:   pix_ch.ready <= 1'b1;
					ACCEPT_RANDOM:   pix_ch.ready <= 1'($urandom);
					ACCEPT_SPARSE:   pix_ch.ready <= (phase % 4 == 0);
					ACCEPT_PERIODIC: pix_ch.ready <= (phase % 3 != 0);
				endcase
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			results_seen++;
			seen_pixel.pixel_x = pix_ch.pixel_x;
			seen_pixel.pixel_y = pix_ch.pixel_y;
			seen_pixel.pixel_rgb = pix_ch.pixel_rgb;
			seen_pixel.has_pixel = pix_ch.has_pixel;
			seen_pixel.inside_view = pix_ch.inside_view;
			seen_pixel.last = pix_ch.last;
			if (pending_pixels.size() == 0) begin
				report_mismatch("pixel with no pending command", 0, 0);
			end else begin
				due_pixel = pending_pixels.pop_front();
				if (seen_pixel.pixel_x !== due_pixel.pixel_x)
					report_mismatch("pixel_x", int'(seen_pixel.pixel_x),
						int'(due_pixel.pixel_x));
				if (seen_pixel.pixel_y !== due_pixel.pixel_y)
					report_mismatch("pixel_y", int'(seen_pixel.pixel_y),
						int'(due_pixel.pixel_y));
				if (seen_pixel.pixel_rgb !== due_pixel.pixel_rgb)
					report_mismatch("pixel_rgb", int'(seen_pixel.pixel_rgb),
						int'(due_pixel.pixel_rgb));
				if (seen_pixel.has_pixel !== due_pixel.has_pixel)
					report_mismatch("has_pixel", int'(seen_pixel.has_pixel),
						int'(due_pixel.has_pixel));
				if (seen_pixel.inside_view !== due_pixel.inside_view)
					report_mismatch("inside_view", int'(seen_pixel.inside_view),
						int'(due_pixel.inside_view));
				if (seen_pixel.last !== due_pixel.last)
					report_mismatch("last", int'(seen_pixel.last), int'(due_pixel.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("bresenham_line_rasterizer test failed");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= bres_pkg::REG_VIEW_WIDTH;
		cfg_data <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.kind <= bres_pkg::KIND_STEP;
		cmd_ch.x_start <= '0;
		cmd_ch.y_start <= '0;
		cmd_ch.x_end <= '0;
		cmd_ch.y_end <= '0;
		cmd_ch.rgb <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_lines(460);
		wait_drained();
		test_output_backpressure();
		test_view_settings();

		if (mismatch_count == 0 && pending_pixels.size() == 0) begin
			$display("bresenham_line_rasterizer test passed");
		end else begin
			$display("bresenham_line_rasterizer test failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/bres_pkg.sv
design/bres_cmd_if.sv
design/bres_pix_if.sv
design/bresenham_line_rasterizer.sv
bench/bresenham_line_rasterizer_tb.sv
